// ===== src/evs_pkg.sv =====
// Shared types, mode and command codes, and valve masks for the engine valve sequencer.
package evs_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [6:0] valves_t;
	typedef logic [3:0] cmd_t;
	typedef logic [1:0] cfg_idx_t;
	typedef logic [31:0] ms_t;

	localparam mode_t MODE_IDLE   = 3'd0;
	localparam mode_t MODE_ARMED  = 3'd1;
	localparam mode_t MODE_HOT    = 3'd2;
	localparam mode_t MODE_MANUAL = 3'd3;
	localparam mode_t MODE_KEY    = 3'd4;

	localparam cmd_t CMD_TOGGLE_FIRST = 4'd1;
	localparam cmd_t CMD_TOGGLE_LAST  = 4'd7;
	localparam cmd_t CMD_PRESSURIZE   = 4'd8;
	localparam cmd_t CMD_DEPRESSURIZE = 4'd9;
	localparam cmd_t CMD_FIRE         = 4'd10;
	localparam cmd_t CMD_ABORT        = 4'd11;
	localparam cmd_t CMD_MANUAL       = 4'd12;
	localparam cmd_t CMD_ORIGIN       = 4'd13;

	localparam cfg_idx_t CFG_FIRE_DURATION  = 2'd0;
	localparam cfg_idx_t CFG_PURGE_DURATION = 2'd1;
	localparam cfg_idx_t CFG_KERO_DELAY     = 2'd2;

	localparam valves_t V_KISO  = 7'h01;
	localparam valves_t V_LISO  = 7'h02;
	localparam valves_t V_KMAIN = 7'h04;
	localparam valves_t V_LMAIN = 7'h08;
	localparam valves_t V_KVENT = 7'h10;
	localparam valves_t V_LVENT = 7'h20;
	localparam valves_t V_PURGE = 7'h40;
	localparam valves_t V_NONE  = 7'h00;

	localparam ms_t IDLE_PURGE_MS      = 32'd4000;
	localparam ms_t IGNITION_WINDOW_MS = 32'd3000;

	localparam ms_t FIRE_DURATION_RESET  = 32'd5000;
	localparam ms_t PURGE_DURATION_RESET = 32'd4000;
	localparam ms_t KERO_DELAY_RESET     = 32'd100;

endpackage

// ===== src/engine_valve_sequencer.sv =====
// Engine valve sequencer: input register, mode and valve update logic, and result register.
//
// Each transfer on the input channel carries one tick: a command code, the key switch and
// break-wire levels and the time elapsed since the last timer restart. The block answers
// every tick with exactly one result: the new mode, the seven valve bits, the igniter level,
// a flag that says the tick changed mode or valves, and a request to restart the elapsed-time
// reference. A tick is taken into an input register, evaluated against the held state by
// combinational compare and flag logic, and its result is written into the output
// register. One tick can be taken every cycle while the output side keeps up. The three
// timing registers are written through the configuration port and should only be changed
// while no tick is in flight.
module engine_valve_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  evs_pkg::cfg_idx_t   cfg_index,
	input  evs_pkg::ms_t        cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  evs_pkg::cmd_t       req_type,
	input  logic                key_switch,
	input  logic                break_wire,
	input  evs_pkg::ms_t        time_elapsed_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output evs_pkg::mode_t      mode,
	output evs_pkg::valves_t    valves,
	output logic                igniter,
	output logic                changed,
	output logic                restart_timer
);
	import evs_pkg::*;

	ms_t     fire_duration_q;
	ms_t     purge_duration_q;
	ms_t     kero_delay_q;

	logic    valid_s1;
	cmd_t    req_type_s1;
	logic    key_switch_s1;
	logic    break_wire_s1;
	ms_t     time_elapsed_s1;

	mode_t   mode_q;
	valves_t valves_q;
	logic    igniter_q;
	logic    fire_ended_q;
	logic    ignition_seen_q;
	logic    out_valid_q;
	logic    changed_q;
	logic    restart_q;

	logic    advance;
	mode_t   mode_nx;
	valves_t valves_nx;
	logic    igniter_nx;
	logic    fire_ended_nx;
	logic    ignition_seen_nx;
	logic    chg_nx;
	logic    restart_nx;
	logic    lox_open;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_duration_q  <= FIRE_DURATION_RESET;
			purge_duration_q <= PURGE_DURATION_RESET;
			kero_delay_q     <= KERO_DELAY_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FIRE_DURATION:  fire_duration_q  <= cfg_data;
				CFG_PURGE_DURATION: purge_duration_q <= cfg_data;
				CFG_KERO_DELAY:     kero_delay_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1     <= req_type;
			key_switch_s1   <= key_switch;
			break_wire_s1   <= break_wire;
			time_elapsed_s1 <= time_elapsed_ms;
		end
	end

	always_comb begin
		mode_nx          = mode_q;
		valves_nx        = valves_q;
		igniter_nx       = igniter_q;
		fire_ended_nx    = fire_ended_q;
		ignition_seen_nx = ignition_seen_q;
		chg_nx           = 1'b0;
		restart_nx       = 1'b0;
		lox_open         = 1'b0;

		if (mode_q != MODE_KEY && !key_switch_s1) begin
			mode_nx   = MODE_KEY;
			valves_nx = V_PURGE;
			chg_nx    = 1'b1;
		end

		unique case (mode_q)
			MODE_IDLE: begin
				if (req_type_s1 == CMD_PRESSURIZE) begin
					mode_nx   = MODE_ARMED;
					valves_nx = valves_nx | V_KISO | V_LISO | V_KVENT | V_LVENT;
					chg_nx    = 1'b1;
				end
				if (req_type_s1 == CMD_MANUAL) begin
					mode_nx = MODE_MANUAL;
					chg_nx  = 1'b1;
				end
				if ((valves_nx & V_PURGE) != V_NONE && time_elapsed_s1 >= IDLE_PURGE_MS) begin
					valves_nx     = valves_nx & ~V_PURGE;
					fire_ended_nx = 1'b0;
					chg_nx        = 1'b1;
				end
			end
			MODE_ARMED: begin
				if (req_type_s1 == CMD_FIRE) begin
					igniter_nx = 1'b1;
					restart_nx = 1'b1;
					mode_nx    = MODE_HOT;
					chg_nx     = 1'b1;
				end
				if (req_type_s1 == CMD_DEPRESSURIZE) begin
					mode_nx   = MODE_IDLE;
					valves_nx = valves_nx & ~(V_KISO | V_LISO | V_KVENT | V_LVENT);
					chg_nx    = 1'b1;
				end
				if (req_type_s1 == CMD_MANUAL) begin
					mode_nx = MODE_MANUAL;
					chg_nx  = 1'b1;
				end
			end
			MODE_HOT: begin
				if (req_type_s1 == CMD_ABORT) begin
					valves_nx     = V_PURGE;
					mode_nx       = MODE_IDLE;
					restart_nx    = 1'b1;
					fire_ended_nx = 1'b1;
					chg_nx        = 1'b1;
				end
				if (req_type_s1 == CMD_MANUAL) begin
					mode_nx = MODE_MANUAL;
					chg_nx  = 1'b1;
				end
				lox_open = (valves_nx & V_LMAIN) != V_NONE;
				priority if (time_elapsed_s1 <= IGNITION_WINDOW_MS && !break_wire_s1
						&& !lox_open && !fire_ended_nx) begin
					valves_nx        = valves_nx | V_LMAIN;
					igniter_nx       = 1'b0;
					ignition_seen_nx = 1'b1;
					restart_nx       = 1'b1;
					chg_nx           = 1'b1;
				end else if (time_elapsed_s1 >= kero_delay_q && lox_open
						&& (valves_nx & V_KMAIN) == V_NONE && ignition_seen_nx
						&& !fire_ended_nx) begin
					valves_nx = valves_nx | V_KMAIN;
					chg_nx    = 1'b1;
				end else if (time_elapsed_s1 >= fire_duration_q && !fire_ended_nx
						&& ignition_seen_nx) begin
					valves_nx        = (valves_nx & ~(V_KMAIN | V_LMAIN)) | V_PURGE;
					restart_nx       = 1'b1;
					fire_ended_nx    = 1'b1;
					ignition_seen_nx = 1'b0;
					chg_nx           = 1'b1;
				end else if (time_elapsed_s1 > purge_duration_q && fire_ended_nx
						&& !ignition_seen_nx) begin
					valves_nx     = V_NONE;
					mode_nx       = MODE_IDLE;
					fire_ended_nx = 1'b0;
					chg_nx        = 1'b1;
				end else if (time_elapsed_s1 > IGNITION_WINDOW_MS && break_wire_s1
						&& !lox_open) begin
					mode_nx       = MODE_ARMED;
					igniter_nx    = 1'b0;
					fire_ended_nx = 1'b0;
					chg_nx        = 1'b1;
				end else begin
					// No timed step applies on this tick.
				end
			end
			MODE_MANUAL: begin
				if (req_type_s1 == CMD_ORIGIN) begin
					valves_nx = V_NONE;
					mode_nx   = MODE_IDLE;
					chg_nx    = 1'b1;
				end
				if (req_type_s1 == CMD_PRESSURIZE && (valves_nx & V_KISO) != V_NONE
						&& (valves_nx & V_LISO) != V_NONE
						&& (valves_nx & (V_KMAIN | V_LMAIN)) == V_NONE) begin
					mode_nx = MODE_ARMED;
					chg_nx  = 1'b1;
				end
				if (req_type_s1 >= CMD_TOGGLE_FIRST && req_type_s1 <= CMD_TOGGLE_LAST) begin
					valves_nx = valves_nx ^ (7'h01 << (req_type_s1 - CMD_TOGGLE_FIRST));
					chg_nx    = 1'b1;
				end
			end
			default: begin
				if (key_switch_s1) begin
					mode_nx = MODE_IDLE;
					chg_nx  = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_IDLE;
			valves_q        <= V_NONE;
			igniter_q       <= 1'b0;
			fire_ended_q    <= 1'b0;
			ignition_seen_q <= 1'b0;
			out_valid_q     <= 1'b0;
			changed_q       <= 1'b0;
			restart_q       <= 1'b0;
		end else begin
			if (advance) begin
				mode_q          <= mode_nx;
				valves_q        <= valves_nx;
				igniter_q       <= igniter_nx;
				fire_ended_q    <= fire_ended_nx;
				ignition_seen_q <= ignition_seen_nx;
				changed_q       <= chg_nx;
				restart_q       <= restart_nx;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign mode          = mode_q;
	assign valves        = valves_q;
	assign igniter       = igniter_q;
	assign changed       = changed_q;
	assign restart_timer = restart_q;

	// A timer restart always comes with a change of mode or valves.
	a_restart_implies_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && restart_q |-> changed_q)
		else $error("restart_timer without changed");

	// The held state moves only when a tick is evaluated.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_q) && $stable(valves_q) && $stable(igniter_q))
		else $error("state changed without an evaluated tick");

	// A tick that reports no change leaves mode and valves as they were.
	a_no_change_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !chg_nx |-> mode_nx == mode_q && valves_nx == valves_q)
		else $error("mode or valves changed while changed is low");

	// The input stage is never overwritten while it holds an unevaluated tick.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !in_ready)
		else $error("input register accepted a transfer while occupied");

endmodule
